>>> sv/tdpt_pkg.sv
// Package for the trial-division primality tester.
// Holds the controller state type and the command and status bundles.
// No dependencies.
package tdpt_pkg;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_TEST,
        ST_DIVIDE,
        ST_JUDGE,
        ST_FINISH
    } tdpt_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the incoming number, reset the divisor
        logic div_start;  // begin a remainder computation
        logic div_step;   // one restoring division step
        logic advance;    // move to the next odd divisor
        logic publish;    // write the verdict to the output register
        logic verdict;    // verdict written by publish
    } tdpt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic n_lt2;      // number is 0 or 1
        logic n_eq2;      // number is 2
        logic n_even;     // number is even
        logic sq_gt_n;    // divisor squared exceeds the number
        logic div_last;   // current division step is the final one
        logic rem_zero;   // remainder of the finished division is zero
        logic out_free;   // output register can take a new result
    } tdpt_status_t;

    // First odd divisor that is tried, and its square.
    localparam int FIRST_DIVISOR = 3;
    localparam int FIRST_SQUARE  = 9;

endpackage

>>> sv/tdpt_dpath.sv
// Datapath of the trial-division primality tester: number, divisor,
// running square, bit-serial remainder unit and output register.
// Depends on tdpt_pkg.
module tdpt_dpath #(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  tdpt_pkg::tdpt_cmd_t       cmd,
    output tdpt_pkg::tdpt_status_t    status,
    input  logic [NUMBER_WIDTH-1:0]   in_number,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic                      out_prime
);
    import tdpt_pkg::*;

    localparam int W     = NUMBER_WIDTH;
    localparam int CNT_W = $clog2(W);
    localparam int SQ_W  = W + 2;

    logic [W-1:0]     n_reg;
    logic [W-1:0]     d_reg;
    logic [SQ_W-1:0]  sq_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     rem_next;
    logic [W-1:0]     dvd_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             out_valid_reg;
    logic             out_prime_reg;
    logic [W:0]       shifted;

    // One restoring division step: bring in the next dividend bit and
    // subtract the divisor when it fits. The partial remainder stays below
    // twice the divisor, so the difference fits in W bits.
    always_comb begin
        shifted = {rem_reg, dvd_reg[W-1]};
        if (shifted >= {1'b0, d_reg}) begin
            rem_next = W'(shifted - {1'b0, d_reg});
        end else begin
            rem_next = shifted[W-1:0];
        end
    end

    // Number, divisor and running square. (d+2)^2 = d^2 + 4d + 4.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            n_reg  <= in_number;
            d_reg  <= W'(FIRST_DIVISOR);
            sq_reg <= SQ_W'(FIRST_SQUARE);
        end else if (cmd.advance) begin
            d_reg  <= d_reg + W'(2);
            sq_reg <= sq_reg + {d_reg, 2'b00} + SQ_W'(4);
        end
    end

    // Remainder unit, one quotient bit per cycle, most significant first.
    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            rem_reg <= '0;
            dvd_reg <= n_reg;
            cnt_reg <= CNT_W'(W - 1);
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[W-2:0], 1'b0};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // Output register; it frees up when the receiver takes the beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.publish) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            out_prime_reg <= cmd.verdict;
        end
    end

    // Status toward the controller.
    always_comb begin
        status.n_lt2    = (n_reg < W'(2));
        status.n_eq2    = (n_reg == W'(2));
        status.n_even   = ~n_reg[0];
        status.sq_gt_n  = (sq_reg > {2'b00, n_reg});
        status.div_last = (cnt_reg == '0);
        status.rem_zero = (rem_reg == '0);
        status.out_free = ~out_valid_reg | out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_prime = out_prime_reg;

endmodule

>>> sv/tdpt_ctrl.sv
// Controller of the trial-division primality tester: sequences the
// classification, the divisor loop and the hand-off to the output register.
// Depends on tdpt_pkg.
module tdpt_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  tdpt_pkg::tdpt_status_t status,
    output tdpt_pkg::tdpt_cmd_t    cmd
);
    import tdpt_pkg::*;

    tdpt_state_t state_reg;
    tdpt_state_t state_next;
    logic        verdict_reg;
    logic        verdict_next;

    // State and pending verdict.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            verdict_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            verdict_reg <= verdict_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next   = state_reg;
        verdict_next = verdict_reg;
        cmd          = '0;
        cmd.verdict  = verdict_reg;
        in_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY: begin
                // Small values and even values are settled at once.
                if (status.n_lt2) begin
                    verdict_next = 1'b0;
                    state_next   = ST_FINISH;
                end else if (status.n_eq2) begin
                    verdict_next = 1'b1;
                    state_next   = ST_FINISH;
                end else if (status.n_even) begin
                    verdict_next = 1'b0;
                    state_next   = ST_FINISH;
                end else begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST: begin
                // No divisor up to the square root: the number is prime.
                if (status.sq_gt_n) begin
                    verdict_next = 1'b1;
                    state_next   = ST_FINISH;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_JUDGE;
                end
            end
            ST_JUDGE: begin
                if (status.rem_zero) begin
                    verdict_next = 1'b0;
                    state_next   = ST_FINISH;
                end else begin
                    cmd.advance = 1'b1;
                    state_next  = ST_TEST;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/trial_division_primality_test_unit.sv
// Top level of the trial-division primality tester.
// Instantiates tdpt_ctrl and tdpt_dpath; depends on tdpt_pkg.
//
// Usage: each beat on the s_ channel carries one unsigned number in the low
// NUMBER_WIDTH bits of s_tdata; each beat on the m_ channel returns one
// verdict in m_tdata bit 0 (1 = prime). One result per number, in order.
// Zero, one, two and the other even numbers are settled by classification
// alone, without a trial. An odd number n tries odd divisors d = 3, 5, ...
// while d*d <= n, with trials up to sqrt(n)/2; each trial runs through the
// bit-serial remainder unit, between the divisor test and the judgement.
// The square d*d is kept as a running sum, so no multiplier is used.
// One number is worked on at a time; s_tready is high only while the block
// is waiting for a number. A finished verdict sits in the output register,
// and the next number is taken while it waits; if the receiver still stalls
// when the following verdict is ready, the block holds it and waits.
// After reset (aresetn low at a clock edge) both channels are empty and the
// block is ready for a number.
module trial_division_primality_test_unit #(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: number (NUMBER_WIDTH bits), zero fill.
    input  logic [((NUMBER_WIDTH+7)/8)*8-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0: prime_flag (1 bit), zero fill.
    output logic [7:0]                          m_tdata
);
    import tdpt_pkg::*;

    tdpt_cmd_t    cmd;
    tdpt_status_t status;
    logic         out_prime;

    tdpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tdpt_dpath #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_number (s_tdata[NUMBER_WIDTH-1:0]),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_prime (out_prime)
    );

    assign m_tdata = {7'b0, out_prime};

    // After a number is taken, no other is taken in the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a number is in progress");

    // A verdict never overwrites one the receiver has not taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |-> (!m_tvalid || m_tready))
        else $error("verdict written over a pending result");

    // Among even numbers only two is reported prime.
    a_even_prime: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish && cmd.verdict && status.n_even |-> status.n_eq2)
        else $error("even number other than two reported prime");

endmodule

>>> dv/trial_division_primality_test_unit_test.sv
// Self-checking testbench for trial_division_primality_test_unit.
// Sends numbers on the s_ stream, predicts each verdict by trial division and
// checks every m_ beat in order; depends only on the unit's RTL.
module trial_division_primality_test_unit_test;

    localparam int NUMBER_WIDTH = 32;
    localparam int DATA_BITS    = ((NUMBER_WIDTH + 7) / 8) * 8;
    // Longest item used here is a prime near 2^20: about 512 trials.
    localparam int IDLE_LIMIT   = 100000;
    localparam int DRAIN_CYCLES = 2 * (NUMBER_WIDTH + 2) + 8;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [DATA_BITS-1:0] s_tdata  = '0;   // number (NUMBER_WIDTH bits), zero fill
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [7:0]           m_tdata;         // prime_flag (1 bit), zero fill

    typedef struct {
        logic [NUMBER_WIDTH-1:0] number;
        bit                      prime_flag;
    } verdict_t;

    verdict_t expected_verdicts[$];
    int       fail_count    = 0;
    int       numbers_sent  = 0;
    int       primes_seen   = 0;
    int       idle_cycles   = 0;
    int       stall_left    = 0;
    bit       quiet         = 1'b0;

    trial_division_primality_test_unit #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Clock with a period of 8.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Verdict by trial division over odd divisors up to the square root.
    function automatic bit predict_prime(logic [NUMBER_WIDTH-1:0] n);
        longint unsigned value;
        longint unsigned divisor;
        value = n;
        if (value < 2)
            return 1'b0;
        if (value == 2)
            return 1'b1;
        if (value[0] == 1'b0)
            return 1'b0;
        for (divisor = 3; divisor * divisor <= value; divisor += 2) begin
            if (value % divisor == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Send one number, with an optional idle burst first, and record its verdict.
    task automatic send_number(input logic [NUMBER_WIDTH-1:0] n);
        verdict_t entry;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_BITS'(n);
        do @(posedge aclk); while (!s_tready);
        entry.number     = n;
        entry.prime_flag = predict_prime(n);
        if (entry.prime_flag)
            primes_seen++;
        expected_verdicts.push_back(entry);
        numbers_sent++;
    endtask

    // Result checking, receiver stalls and the idle watchdog.
    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("prime_flag: no verdict expected, got %0d", m_tdata[0]);
                    fail_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (m_tdata[0] !== want.prime_flag) begin
                        $error("prime_flag for %0d: expected %0d, got %0d",
                               want.number, want.prime_flag, m_tdata[0]);
                        fail_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("trial_division_primality_test_unit: mismatch");
                $finish;
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Zero, one, two, three and the first small numbers.
    task automatic test_trivial_values();
        send_number(0);
        send_number(1);
        send_number(2);
        send_number(3);
        send_number(4);
        send_number(5);
    endtask

    // Values at the edges of the field; the odd ones resolve on the first trial, the even ones without any.
    task automatic test_width_extremes();
        send_number(32'hFFFF_FFFF);
        send_number(32'hFFFF_FFFE);
        send_number(32'h8000_0000);
        send_number(32'h8000_0001);
        send_number(32'h7FFF_FFFE);
    endtask

    // Squares of primes, where the last trial is the one that divides, and
    // longer runs of trials.
    task automatic test_square_edges();
        send_number(9);
        send_number(25);
        send_number(49);
        send_number(65537);
        send_number(1021 * 1019);
        // The largest prime below 2^20.
        send_number(1048573);
    endtask

    // Bulk of the random part: small numbers keep each item short.
    task automatic test_small_random();
        repeat (63) send_number($urandom_range(0, 4095));
    endtask

    // A few medium numbers with up to about 512 trials.
    task automatic test_mid_random();
        repeat (10) send_number($urandom_range(4096, 1 << 20));
    endtask

    // Full-width numbers that are even or multiples of three, so they stay fast.
    task automatic test_wide_random();
        repeat (15) send_number($urandom & 32'hFFFF_FFFE);
        repeat (15) send_number(3 * $urandom_range(1, 32'h5555_5555));
    endtask

    // Closing stretch with no gaps on either side.
    task automatic test_back_to_back();
        quiet = 1'b1;
        repeat (20) send_number($urandom_range(0, 1023));
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_trivial_values();
        test_width_extremes();
        test_square_edges();
        test_small_random();
        test_mid_random();
        test_wide_random();
        test_back_to_back();
        s_tvalid <= 1'b0;

        // Let every outstanding verdict arrive, then watch for stray beats.
        while (expected_verdicts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Tested %0d numbers (%0d prime): small values, field extremes,",
                 numbers_sent, primes_seen);
        $display("prime squares, random small, medium and full-width values.");
        if (fail_count == 0)
            $display("trial_division_primality_test_unit: match");
        else
            $display("trial_division_primality_test_unit: mismatch");
        $finish;
    end

endmodule
